### design/icsp_pkg.sv
// ----------------------------------------------------------------------------
// icsp_pkg
// Types, command codes and frame constants of the in-circuit programming
// sequencer.
// ----------------------------------------------------------------------------
package icsp_pkg;

   localparam int unsigned HEADER_BYTES = 7;
   localparam int unsigned MAX_RESULTS  = 4;

   // result actions
   localparam logic [1:0] ACT_FRAME = 2'd0;
   localparam logic [1:0] ACT_ENTER = 2'd1;
   localparam logic [1:0] ACT_EXIT  = 2'd2;

   // command bytes
   localparam logic [7:0] CMD_LOAD_ADDR = 8'h80;
   localparam logic [7:0] CMD_WRITE     = 8'hE0;
   localparam logic [7:0] CMD_ERASE     = 8'h18;

   localparam logic [31:0] KEY_WORD       = 32'h4D43_4850;
   localparam logic [23:0] ERASE_PAYLOAD  = 24'h00000F;
   localparam logic [23:0] ADDR_PROGRAM   = 24'h000000;
   localparam logic [23:0] ADDR_EEPROM    = 24'h380000;
   localparam logic [23:0] ADDR_CONFIG    = 24'h300000;
   localparam logic [31:0] SKIP_WORD      = 32'h0000_00F8;

   localparam logic [5:0] BITS_NONE  = 6'd0;
   localparam logic [5:0] BITS_BYTE  = 6'd8;
   localparam logic [5:0] BITS_FRAME = 6'd32;

   localparam logic [15:0] WAIT_NONE       = 16'd0;
   localparam logic [15:0] WAIT_KEY        = 16'd2000;
   localparam logic [15:0] WAIT_ERASE      = 16'd2000;
   localparam logic [15:0] WAIT_FIRST_ADDR = 16'd20100;
   localparam logic [15:0] WAIT_PROG_DONE  = 16'd100;
   localparam logic [15:0] WAIT_EE_DONE    = 16'd20000;
   localparam logic [15:0] WAIT_EXIT       = 16'd50000;

   typedef enum logic [4:0] {
      PH_READY   = 5'b00001,
      PH_HEADER  = 5'b00010,
      PH_PROGRAM = 5'b00100,
      PH_EEPROM  = 5'b01000,
      PH_CONFIG  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] frame_word;
      logic [5:0]  frame_bits;
      logic [15:0] wait_before_us;
   } result_type;

   // command byte, then the payload shifted left by one (payload bit 23 drops)
   function automatic logic [31:0] make_frame(logic [7:0] cmd, logic [23:0] payload);
      make_frame = {cmd, payload[22:0], 1'b0};
   endfunction

   function automatic result_type frame_result(logic [31:0] word, logic [15:0] wait_us);
      result_type r;
      r.action         = ACT_FRAME;
      r.frame_word     = word;
      r.frame_bits     = BITS_FRAME;
      r.wait_before_us = wait_us;
      frame_result     = r;
   endfunction

   function automatic result_type ctrl_result(logic [1:0] act, logic [15:0] wait_us);
      result_type r;
      r.action         = act;
      r.frame_word     = 32'd0;
      r.frame_bits     = BITS_NONE;
      r.wait_before_us = wait_us;
      ctrl_result      = r;
   endfunction

endpackage

### design/icsp_programming_sequencer.sv
// ----------------------------------------------------------------------------
// icsp_programming_sequencer
// Turns a host byte stream into programming-mode, key, erase, address, write
// and skip frames for an 8-bit microcontroller's serial programming port.
// ----------------------------------------------------------------------------
// Each host byte is decoded in the cycle it is accepted and its results (zero
// to four) land in a four-entry result buffer, which drains one result per
// cycle on the rsp channel while rsp_ready is high. A byte with no results
// frees req_ready at once; otherwise req_ready stays low until its last result
// is being taken. The header-complete byte is the four-result case; EEPROM and
// config bytes and every second program byte give one; a region's last byte adds one.
module icsp_programming_sequencer
   import icsp_pkg::*;
#(
   parameter int unsigned CONFIG_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_host_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_frame_word,
   output logic [5:0]  rsp_frame_bits,
   output logic [15:0] rsp_wait_before_us,
   output logic        rsp_last
);

   phase_type                 phase_ff, phase_in;
   logic [2:0]                hdr_idx_ff, hdr_idx_in;
   logic [47:0]               hdr_ff, hdr_in;
   logic [23:0]               prog_len_ff, prog_len_in;
   logic [15:0]               ee_len_ff, ee_len_in;
   logic [15:0]               mask_ff, mask_in;
   logic [23:0]               prog_cnt_ff, prog_cnt_in;
   logic [15:0]               ee_cnt_ff, ee_cnt_in;
   logic [CONFIG_BYTES-1:0]   ptr_ff, ptr_in;
   logic [7:0]                held_ff, held_in;

   result_type                res_ff [MAX_RESULTS];
   result_type                res_in [MAX_RESULTS];
   logic [2:0]                cnt_ff, cnt_in;

   result_type                new_res [MAX_RESULTS];
   logic [2:0]                new_cnt;

   logic                      req_take;
   logic                      rsp_take;
   logic [55:0]               hdr_full;
   logic [23:0]               prog_cnt_inc;
   logic [15:0]               ee_cnt_inc;

   assign req_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_take  = rsp_valid && rsp_ready;

   assign rsp_action         = res_ff[0].action;
   assign rsp_frame_word     = res_ff[0].frame_word;
   assign rsp_frame_bits     = res_ff[0].frame_bits;
   assign rsp_wait_before_us = res_ff[0].wait_before_us;
   assign rsp_last           = (cnt_ff == 3'd1);

   assign hdr_full     = {hdr_ff, req_host_byte};
   assign prog_cnt_inc = prog_cnt_ff + 24'd1;
   assign ee_cnt_inc   = ee_cnt_ff + 16'd1;

   // decode one byte: next state and the list of results it causes
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      hdr_in      = hdr_ff;
      prog_len_in = prog_len_ff;
      ee_len_in   = ee_len_ff;
      mask_in     = mask_ff;
      prog_cnt_in = prog_cnt_ff;
      ee_cnt_in   = ee_cnt_ff;
      ptr_in      = ptr_ff;
      held_in     = held_ff;
      new_cnt     = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         new_res[i] = ctrl_result(ACT_FRAME, WAIT_NONE);
      end

      case (phase_ff)
         PH_HEADER: begin
            hdr_in     = hdr_full[47:0];
            hdr_idx_in = hdr_idx_ff + 3'd1;
            if (hdr_idx_ff == 3'(HEADER_BYTES - 1)) begin
               prog_len_in = hdr_full[55:32];
               ee_len_in   = hdr_full[31:16];
               mask_in     = hdr_full[15:0];
               prog_cnt_in = 24'd0;
               ee_cnt_in   = 16'd0;
               ptr_in      = '0;
               ptr_in[CONFIG_BYTES-1] = 1'b1;
               new_res[0]  = ctrl_result(ACT_ENTER, WAIT_NONE);
               new_res[1]  = frame_result(KEY_WORD, WAIT_KEY);
               new_res[2]  = frame_result(make_frame(CMD_ERASE, ERASE_PAYLOAD), WAIT_ERASE);
               new_cnt     = 3'd4;
               if (hdr_full[55:32] != 24'd0) begin
                  new_res[3] = frame_result(make_frame(CMD_LOAD_ADDR, ADDR_PROGRAM),
                                            WAIT_FIRST_ADDR);
                  phase_in   = PH_PROGRAM;
               end else if (hdr_full[31:16] != 16'd0) begin
                  new_res[3] = frame_result(make_frame(CMD_LOAD_ADDR, ADDR_EEPROM),
                                            WAIT_FIRST_ADDR);
                  phase_in   = PH_EEPROM;
               end else begin
                  new_res[3] = frame_result(make_frame(CMD_LOAD_ADDR, ADDR_CONFIG),
                                            WAIT_FIRST_ADDR);
                  phase_in   = PH_CONFIG;
               end
            end
         end
         PH_PROGRAM: begin
            prog_cnt_in = prog_cnt_inc;
            if (!prog_cnt_ff[0]) begin
               held_in = req_host_byte;
            end else begin
               new_res[0] = frame_result(make_frame(CMD_WRITE, {8'd0, held_ff, req_host_byte}),
                                         WAIT_NONE);
               new_cnt    = 3'd1;
            end
            if (prog_cnt_inc == prog_len_ff) begin
               if (ee_len_ff != 16'd0) begin
                  new_res[new_cnt[1:0]] =
                     frame_result(make_frame(CMD_LOAD_ADDR, ADDR_EEPROM), WAIT_PROG_DONE);
                  phase_in = PH_EEPROM;
               end else begin
                  new_res[new_cnt[1:0]] =
                     frame_result(make_frame(CMD_LOAD_ADDR, ADDR_CONFIG), WAIT_PROG_DONE);
                  phase_in = PH_CONFIG;
               end
               new_cnt = new_cnt + 3'd1;
            end
         end
         PH_EEPROM: begin
            ee_cnt_in  = ee_cnt_inc;
            new_res[0] = frame_result(make_frame(CMD_WRITE, {16'd0, req_host_byte}), WAIT_NONE);
            new_cnt    = 3'd1;
            if (ee_cnt_inc == ee_len_ff) begin
               new_res[1] = frame_result(make_frame(CMD_LOAD_ADDR, ADDR_CONFIG), WAIT_EE_DONE);
               new_cnt    = 3'd2;
               phase_in   = PH_CONFIG;
            end
         end
         PH_CONFIG: begin
            if ((mask_ff[CONFIG_BYTES-1:0] & ptr_ff) != '0) begin
               new_res[0] = frame_result(make_frame(CMD_WRITE, {16'd0, req_host_byte}),
                                         WAIT_NONE);
            end else begin
               new_res[0] = frame_result(SKIP_WORD, WAIT_NONE);
               new_res[0].frame_bits = BITS_BYTE;
            end
            new_cnt = 3'd1;
            ptr_in  = ptr_ff >> 1;
            if (ptr_ff[0]) begin
               new_res[1] = ctrl_result(ACT_EXIT, WAIT_EXIT);
               new_cnt    = 3'd2;
               phase_in   = PH_READY;
            end
         end
         default: begin
            // arming byte: value ignored
            hdr_idx_in = 3'd0;
            phase_in   = PH_HEADER;
         end
      endcase
   end

   // result buffer: load on a new item, otherwise drop the head when taken
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = res_ff[i];
      end
      if (req_take) begin
         cnt_in = new_cnt;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_in[i] = new_res[i];
         end
      end else if (rsp_take) begin
         cnt_in = cnt_ff - 3'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_READY;
         hdr_idx_ff  <= 3'd0;
         prog_len_ff <= 24'd0;
         ee_len_ff   <= 16'd0;
         mask_ff     <= 16'd0;
         prog_cnt_ff <= 24'd0;
         ee_cnt_ff   <= 16'd0;
         ptr_ff      <= '0;
         held_ff     <= 8'd0;
         cnt_ff      <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_take) begin
            phase_ff    <= phase_in;
            hdr_idx_ff  <= hdr_idx_in;
            prog_len_ff <= prog_len_in;
            ee_len_ff   <= ee_len_in;
            mask_ff     <= mask_in;
            prog_cnt_ff <= prog_cnt_in;
            ee_cnt_ff   <= ee_cnt_in;
            ptr_ff      <= ptr_in;
            held_ff     <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hdr_ff <= hdr_in;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_ff[i] <= res_in[i];
      end
   end

   // buffer never holds more than one byte's results
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MAX_RESULTS))
      else $error("result buffer count out of range");

   // a new byte only lands once the previous results are drained or draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_take))
      else $error("item accepted over pending results");

   // config pointer is one-hot for the whole config region
   a_ptr_onehot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CONFIG) |-> $onehot(ptr_ff))
      else $error("config pointer not one-hot");

   // the final config byte leaves the block ready with an exit as last result
   a_config_exit: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == PH_CONFIG && ptr_ff[0]) |=>
         (phase_ff == PH_READY) && (cnt_ff == 3'd2) && (res_ff[1].action == ACT_EXIT))
      else $error("config region did not close with exit");

endmodule
